@@ hw/rtl/kde_pkg.sv @@
// Shared types and constants for the key debounce and encoder pulse block.
`default_nettype none

package kde_pkg;

  localparam int unsigned NUM_RAW_KEYS = 3;
  localparam int unsigned KEY_BITS_W   = NUM_RAW_KEYS + 2;
  localparam int unsigned LOCK_W       = 8;
  localparam int unsigned CNT_W        = 8;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 8;
  localparam int unsigned NUM_KEYS_DEF = 3;
  localparam int unsigned SWITCH_IDX   = 2;

  localparam logic [LOCK_W-1:0] KEY_LOCKOUT_RST    = LOCK_W'(25);
  localparam logic [LOCK_W-1:0] SWITCH_LOCKOUT_RST = LOCK_W'(150);
  localparam logic [LOCK_W-1:0] LOCKOUT_INIT       = LOCK_W'(5);

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOCKOUT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_LOCKOUT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ENC_DIRECTION  = CFG_IDX_W'(2);

  typedef struct packed {
    logic [NUM_RAW_KEYS-1:0] raw_keys;
    logic [CNT_W-1:0]        enc_count;
  } kde_in_t;

  typedef struct packed {
    logic [KEY_BITS_W-1:0] key_state;
    logic [KEY_BITS_W-1:0] key_prev;
  } kde_out_t;

endpackage

`default_nettype wire

@@ hw/rtl/kde_lane.sv @@
// One debounce lane: sample history, filtered level and lockout counter for one key.
`default_nettype none

module kde_lane (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          adv_i,
  input  wire                          sample_i,
  input  wire  [kde_pkg::LOCK_W-1:0]   reload_i,
  output logic                         level_o
);
  import kde_pkg::*;

  logic              prev_q;
  logic              filt_q, filt_d;
  logic [LOCK_W-1:0] lock_q, lock_d;
  logic [LOCK_W-1:0] lock_dec;
  logic              take;

  // Count down first, then qualify the change against the decremented value.
  assign lock_dec = (lock_q != '0) ? lock_q - LOCK_W'(1) : '0;
  assign take     = (prev_q == sample_i) && (filt_q != sample_i) && (lock_dec == '0);

  always_comb begin
    filt_d = filt_q;
    lock_d = lock_dec;
    if (take) begin
      filt_d = sample_i;
      lock_d = reload_i;
    end
  end

  assign level_o = filt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 1'b0;
      filt_q <= 1'b0;
      lock_q <= LOCKOUT_INIT;
    end else if (adv_i) begin
      prev_q <= sample_i;
      filt_q <= filt_d;
      lock_q <= lock_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/kde_detent.sv @@
// Encoder detent accumulator and gapped direction pulse generator.
`default_nettype none

module kde_detent (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        adv_i,
  input  wire  [kde_pkg::CNT_W-1:0]  enc_count_i,
  input  wire                        direction_i,
  output logic [1:0]                 pulse_o
);
  import kde_pkg::*;

  logic        [CNT_W-1:0] last_q, last_d;
  logic        [CNT_W-1:0] pend_q, pend_d;
  logic                    gap_q;
  logic signed [CNT_W-1:0] diff;
  logic signed [CNT_W-1:0] biased;
  logic signed [CNT_W-1:0] steps;
  logic        [CNT_W-1:0] pend_acc;

  // Divide by four, truncating toward zero: bias negatives by three, then shift.
  assign diff   = signed'(enc_count_i - last_q);
  assign biased = diff + (diff[CNT_W-1] ? CNT_W'(3) : CNT_W'(0));
  assign steps  = biased >>> 2;

  assign last_d   = last_q + {steps[CNT_W-3:0], 2'b00};
  assign pend_acc = pend_q + CNT_W'(steps);

  always_comb begin
    pend_d  = pend_acc;
    pulse_o = 2'b00;
    if ((pend_acc != '0) && !gap_q) begin
      if (!pend_acc[CNT_W-1]) begin
        pend_d  = pend_acc - CNT_W'(1);
        pulse_o = direction_i ? 2'b01 : 2'b10;
      end else begin
        pend_d  = pend_acc + CNT_W'(1);
        pulse_o = direction_i ? 2'b10 : 2'b01;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      pend_q <= '0;
      gap_q  <= 1'b0;
    end else if (adv_i) begin
      last_q <= last_d;
      pend_q <= pend_d;
      gap_q  <= ~gap_q;
    end
  end

`ifndef SYNTHESIS
  a_gap_no_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && gap_q) |-> (pulse_o == 2'b00))
    else $error("direction pulse issued on a gap tick");

  a_gap_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i |=> (gap_q != $past(gap_q)))
    else $error("gap flag did not toggle on a tick");

  a_pulse_back_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && (pulse_o != 2'b00)) |=> gap_q)
    else $error("pulse not followed by a gap tick");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/key_debounce_encoder_pulses.sv @@
// Top level: key debounce lanes, encoder detent pulses, merge and output buffer.
// Each input word is one scan tick carrying the raw key levels and the low byte of a
// quadrature counter; every accepted word produces exactly one output word. The block
// takes one word per cycle while in_stall_o is low. All per-tick work is combinational
// logic in the debounce lanes and the detent unit; a two-entry output buffer (output
// register plus skid register) keeps input acceptance going while a result waits on a
// stalled consumer. in_stall_o rises only when both entries are full. Each key runs its
// own lane: a lockout counter counts down every tick and the filtered level follows the
// raw level when two samples in a row agree, differ from the filtered level and the
// lockout has reached zero, after which the lockout reloads from key_lockout (or
// switch_lockout for the third key). Encoder counts are turned into detents by
// dividing by four, accumulated as signed pending detents, and released as one-tick
// pulses on bit 0 or bit 1 of key_state with a gap tick between pulses;
// encoder_direction swaps the two bits. key_prev returns the five bits as they stood
// before the tick. Configuration writes are taken at any edge with cfg_we_i high.
`default_nettype none

module key_debounce_encoder_pulses #(
  parameter int unsigned NUM_KEYS = kde_pkg::NUM_KEYS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  kde_pkg::kde_in_t         in_data_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output kde_pkg::kde_out_t              out_data_o,
  input  wire                            cfg_we_i,
  input  wire  [kde_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [kde_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import kde_pkg::*;

  // Configuration registers.
  logic [LOCK_W-1:0] key_lock_q;
  logic [LOCK_W-1:0] sw_lock_q;
  logic              enc_dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lock_q <= KEY_LOCKOUT_RST;
      sw_lock_q  <= SWITCH_LOCKOUT_RST;
      enc_dir_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY_LOCKOUT:    key_lock_q <= cfg_data_i[LOCK_W-1:0];
        CFG_SWITCH_LOCKOUT: sw_lock_q  <= cfg_data_i[LOCK_W-1:0];
        CFG_ENC_DIRECTION:  enc_dir_q  <= cfg_data_i[0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // Handshake.
  logic in_fire;
  logic out_fire;
  logic out_valid_q;
  logic skid_valid_q;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_fire    = out_valid_q && !out_stall_i;

  // Debounce lanes, one per key. Keys beyond the raw inputs see a constant low
  // sample, so their filtered level never leaves zero.
  logic [NUM_KEYS-1:0] lane_level;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic              sample;
    logic [LOCK_W-1:0] reload;

    if (k < NUM_RAW_KEYS) begin : g_raw
      assign sample = in_data_i.raw_keys[k];
    end else begin : g_tie
      assign sample = 1'b0;
    end

    assign reload = (k == SWITCH_IDX) ? sw_lock_q : key_lock_q;

    kde_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (in_fire),
      .sample_i (sample),
      .reload_i (reload),
      .level_o  (lane_level[k])
    );
  end

  // Encoder detents.
  logic [1:0] pulse;

  kde_detent u_detent (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (in_fire),
    .enc_count_i (in_data_i.enc_count),
    .direction_i (enc_dir_q),
    .pulse_o     (pulse)
  );

  // Merge: pulses in bits 0-1, filtered keys above them.
  logic [NUM_RAW_KEYS-1:0] key_lvl;

  for (genvar k = 0; k < NUM_RAW_KEYS; k++) begin : g_merge
    if (k < NUM_KEYS) begin : g_have
      assign key_lvl[k] = lane_level[k];
    end else begin : g_none
      assign key_lvl[k] = 1'b0;
    end
  end

  logic [KEY_BITS_W-1:0] key_bits_q;
  kde_out_t              result;

  assign result.key_state = {key_lvl, pulse};
  assign result.key_prev  = key_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_bits_q <= '0;
    end else if (in_fire) begin
      key_bits_q <= result.key_state;
    end
  end

  // Output register plus skid register.
  kde_out_t out_q;
  kde_out_t skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= result;
      end else begin
        out_q <= result;
      end
    end
  end

  assign out_data_o = out_q;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register is empty");

  a_one_direction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(out_data_o.key_state[1:0]))
    else $error("both direction pulses set in one word");

  a_prev_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !out_valid_q) |=> (out_data_o.key_prev == $past(key_bits_q)))
    else $error("previous key bits do not match the stored state");
`endif

endmodule

`default_nettype wire
